@@ src/tpf_pkg.sv @@
// Package for the tangent point solver: shared types, fixed-point constants,
// saturating add and the elaboration-time arctangent table function.
// No dependencies.
package tpf_pkg;

    localparam int COORD_FRAC_BITS = 28;
    localparam int ANGLE_BITS      = 32;
    localparam int CORDIC_STEPS    = 32;

    // Coordinates move to Q32 by a left or right shift.
    localparam int CO_UP = (COORD_FRAC_BITS < 32) ? 32 - COORD_FRAC_BITS : 0;
    localparam int CO_DN = (COORD_FRAC_BITS > 32) ? COORD_FRAC_BITS - 32 : 0;

    // Digit-by-digit square root: one cell per result bit.
    localparam int SQRT_CELLS = 48;
    // Latency of the pipelined 64 by 64 fixed-point multiplier.
    localparam int QMUL_LAT = 4;

    typedef logic signed [63:0] t_word;

    localparam t_word Q_ONE   = 64'sh0000_0001_0000_0000;
    localparam t_word Q_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam t_word Q_GAIN  = 64'sd2608131496;
    localparam t_word HALF_T  = 64'sd1 <<< (ANGLE_BITS - 1);
    localparam t_word QUART_T = 64'sd1 <<< (ANGLE_BITS - 2);
    localparam t_word BIG_LIM = 64'sd1 <<< 60;

    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;

    typedef struct packed {
        t_word x;
        t_word y;
        t_word z;
    } t_cordic;

    typedef struct packed {
        logic [63:0] v;
        logic [63:0] rem;
        logic [63:0] root;
    } t_sqrt;

    typedef struct packed {
        logic signed [31:0] xi_coord;
        logic signed [31:0] eta_coord;
        logic [31:0]        star_ra;
        logic signed [31:0] star_dec;
    } t_in_req;

    typedef struct packed {
        logic [1:0]         solution_count;
        logic [31:0]        first_ra;
        logic signed [31:0] first_dec;
        logic [31:0]        second_ra;
        logic signed [31:0] second_dec;
    } t_out_req;

    // Sum clamped to plus or minus the largest positive word.
    function automatic t_word sat_add(input t_word a, input t_word b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'(Q_MAX)) return Q_MAX;
        if (s < -65'(Q_MAX)) return -Q_MAX;
        return t_word'(s[63:0]);
    endfunction

    // Restoring division, only used at elaboration to build the table.
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], n[b]};
            if (rem >= {1'b0, d}) begin
                rem  = rem - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Arctangent of 2^-i in Q62 by its power series.
    function automatic logic [63:0] atan_pow2(input int i);
        logic [63:0] sum;
        logic [63:0] term;
        int sh;
        sum = '0;
        for (int k = 0; k < 64; k++) begin
            sh = i * (2 * k + 1);
            if (sh >= 62) break;
            term = udiv64(64'd1 << (62 - sh), 64'(2 * k + 1));
            sum  = k[0] ? sum - term : sum + term;
        end
        return sum;
    endfunction

    // Arctangent of 1/3 in Q62.
    function automatic logic [63:0] atan_third();
        logic [63:0] sum;
        logic [63:0] den;
        logic [63:0] term;
        sum = '0;
        den = 64'd3;
        for (int k = 0; k < 64; k++) begin
            term = udiv64(udiv64(64'd1 << 62, den), 64'(2 * k + 1));
            sum  = k[0] ? sum - term : sum + term;
            if (den > udiv64(64'd1 << 62, 64'd9)) break;
            den = den * 64'd9;
        end
        return sum;
    endfunction

    // Table entry i: atan(2^-i) as a binary angle, rounded half up.
    function automatic t_word atan_entry(input int i);
        logic [63:0] d;
        logic [63:0] rem;
        logic [63:0] q;
        if (i == 0) return 64'sd1 <<< (ANGLE_BITS - 3);
        d   = atan_pow2(1) + atan_third();
        rem = atan_pow2(i);
        q   = '0;
        for (int b = 0; b < ANGLE_BITS - 2; b++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= d) begin
                rem  = rem - d;
                q[0] = 1'b1;
            end
        end
        return t_word'((q + 64'd1) >> 1);
    endfunction

endpackage

@@ src/tpf_stream_if.sv @@
// Valid/ready stream interface carrying one request per handshake.
// Depends on nothing; the payload type is a parameter.
interface tpf_stream_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/tangent_point_from_plane_coords.sv @@
// Top level of the tangent point solver (gnomonic projection solved for the
// tangent point). Depends on tpf_pkg, tpf_stream_if and all tpf_ submodules.
//
//   Port    Dir  Payload    Meaning
//   i_req   in   t_in_req   star xi, eta (Q4.28), RA and Dec (binary angles)
//   o_rsp   out  t_out_req  solution count and two candidate tangent points
//
// One request is accepted per cycle while the output is not stalled. The
// rotation cell chain, the second square root cell chain and the arctangent
// chains lie on the longest path from acceptance to the output register.
// Reset is synchronous and clears only the valid bits of the pipeline.
// When a result sits in the output register and is not taken, the whole
// pipeline holds and i_req.ready drops in the same cycle.
module tangent_point_from_plane_coords #(
    parameter int P_CORDIC_STEPS = tpf_pkg::CORDIC_STEPS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tpf_stream_if.sink    i_req,
    tpf_stream_if.source  o_rsp
);
    import tpf_pkg::*;

    localparam int QL     = QMUL_LAT;
    localparam int L_AT   = P_CORDIC_STEPS + 3;      // atan2 unit latency
    // Cycle at which each value leaves its stage, counted from acceptance.
    localparam int T_CONV = 1;
    localparam int T_SC   = T_CONV + P_CORDIC_STEPS + 1;
    localparam int T_SQ2  = T_CONV + QL;
    localparam int T_SUM1 = T_SQ2 + 1;
    localparam int T_T    = T_SUM1 + 1;
    localparam int T_SQ   = T_T + SQRT_CELLS;
    localparam int T_SDF  = T_SQ + QL;
    localparam int T_CC   = T_SC + QL;
    localparam int T_P    = T_CC + QL;
    localparam int T_R2   = T_P + 1;
    localparam int T_R    = T_R2 + SQRT_CELLS;
    localparam int T_M    = T_R + QL;
    localparam int T_SC2  = T_M + 1;
    localparam int T_AT   = T_SC2 + L_AT;

    // The pipeline advances unless a finished result is stalled at the output.
    logic     w_en;
    logic     r_out_valid;
    t_out_req r_out;

    assign w_en        = !r_out_valid || o_rsp.ready;
    assign i_req.ready = w_en;

    // Input conversion: coordinates to Q32, Dec folded into a quarter turn.
    t_word       r_xq, r_eq, r_zc;
    logic        r_negc;
    logic [31:0] r_ra;
    t_word       n_xq, n_eq, n_zc;
    logic        n_negc;

    always_comb begin
        n_xq   = ($signed(64'($signed(i_req.data.xi_coord))) <<< CO_UP) >>> CO_DN;
        n_eq   = ($signed(64'($signed(i_req.data.eta_coord))) <<< CO_UP) >>> CO_DN;
        n_zc   = 64'($signed(i_req.data.star_dec));
        n_negc = 1'b0;
        if (n_zc > QUART_T) begin
            n_zc   = n_zc - HALF_T;
            n_negc = 1'b1;
        end else if (n_zc < -QUART_T) begin
            n_zc   = n_zc + HALF_T;
            n_negc = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_xq   <= n_xq;
            r_eq   <= n_eq;
            r_zc   <= n_zc;
            r_negc <= n_negc;
            r_ra   <= i_req.data.star_ra;
        end
    end

    // Sine and cosine of Dec through a row of rotation cells.
    t_cordic w_rot [P_CORDIC_STEPS+1];
    logic    w_negc_d;
    t_word   r_sd, r_cd;

    assign w_rot[0] = '{x: Q_GAIN, y: t_word'(0), z: r_zc};

    for (genvar g = 0; g < P_CORDIC_STEPS; g++) begin : g_rot
        tpf_cordic_cell #(.P_STEP(g), .P_VEC(1'b0)) u_rot (
            .i_clk(i_clk), .i_en(w_en), .i_d(w_rot[g]), .o_d(w_rot[g+1])
        );
    end

    tpf_dly #(.P_WIDTH(1), .P_DEPTH(P_CORDIC_STEPS)) u_negc_dly (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_d(r_negc), .o_d(w_negc_d)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd <= w_negc_d ? -w_rot[P_CORDIC_STEPS].y : w_rot[P_CORDIC_STEPS].y;
            r_cd <= w_negc_d ? -w_rot[P_CORDIC_STEPS].x : w_rot[P_CORDIC_STEPS].x;
        end
    end

    // xi^2, eta^2 and the radicand 1 + xi^2 + eta^2.
    t_word w_x2, w_y2;
    t_word r_xy, r_oy, r_t;

    tpf_qmul u_x2 (.i_clk(i_clk), .i_en(w_en), .i_a(r_xq), .i_b(r_xq), .o_p(w_x2));
    tpf_qmul u_y2 (.i_clk(i_clk), .i_en(w_en), .i_a(r_eq), .i_b(r_eq), .o_p(w_y2));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_xy <= sat_add(w_x2, w_y2);
            r_oy <= sat_add(Q_ONE, w_y2);
            r_t  <= sat_add(Q_ONE, r_xy);
        end
    end

    // First square root chain: sqrt(1 + xi^2 + eta^2).
    t_sqrt w_sq1 [SQRT_CELLS+1];

    assign w_sq1[0] = '{v: (r_t > 0) ? r_t : '0, rem: '0, root: '0};

    for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sq1
        tpf_sqrt_cell #(.P_K(SQRT_CELLS - 1 - g)) u_cell (
            .i_clk(i_clk), .i_en(w_en), .i_d(w_sq1[g]), .o_d(w_sq1[g+1])
        );
    end

    // sdf = sin(dec) * sqrt(...).
    t_word w_sd_d, w_sdf;

    tpf_dly #(.P_WIDTH(64), .P_DEPTH(T_SQ - T_SC)) u_sd_dly (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_d(r_sd), .o_d(w_sd_d)
    );
    tpf_qmul u_sdf (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_sd_d), .i_b(t_word'(w_sq1[SQRT_CELLS].root)),
        .o_p(w_sdf)
    );

    // r2 = cos^2(dec)(1 + eta^2) - sin^2(dec) xi^2.
    t_word w_cc, w_ss, w_oy_d, w_x2_d, w_p1, w_p2;
    t_word r_r2;

    tpf_qmul u_cc (.i_clk(i_clk), .i_en(w_en), .i_a(r_cd), .i_b(r_cd), .o_p(w_cc));
    tpf_qmul u_ss (.i_clk(i_clk), .i_en(w_en), .i_a(r_sd), .i_b(r_sd), .o_p(w_ss));

    tpf_dly #(.P_WIDTH(64), .P_DEPTH(T_CC - T_SUM1)) u_oy_dly (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_d(r_oy), .o_d(w_oy_d)
    );
    tpf_dly #(.P_WIDTH(64), .P_DEPTH(T_CC - T_SQ2)) u_x2_dly (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_d(w_x2), .o_d(w_x2_d)
    );

    tpf_qmul u_p1 (.i_clk(i_clk), .i_en(w_en), .i_a(w_cc), .i_b(w_oy_d), .o_p(w_p1));
    tpf_qmul u_p2 (.i_clk(i_clk), .i_en(w_en), .i_a(w_ss), .i_b(w_x2_d), .o_p(w_p2));

    always_ff @(posedge i_clk) begin
        if (w_en) r_r2 <= sat_add(w_p1, -w_p2);
    end

    // Second square root chain: r = sqrt(r2); a negative r2 means no solution.
    t_sqrt w_sq2 [SQRT_CELLS+1];
    t_word w_r;
    logic  w_none_d;

    assign w_sq2[0] = '{v: (r_r2 > 0) ? r_r2 : '0, rem: '0, root: '0};

    for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sq2
        tpf_sqrt_cell #(.P_K(SQRT_CELLS - 1 - g)) u_cell (
            .i_clk(i_clk), .i_en(w_en), .i_d(w_sq2[g]), .o_d(w_sq2[g+1])
        );
    end

    assign w_r = t_word'(w_sq2[SQRT_CELLS].root);

    tpf_dly #(.P_WIDTH(1), .P_DEPTH(T_AT - T_R2)) u_none_dly (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_d(r_r2[63]), .o_d(w_none_d)
    );

    // eta*r and sdf*eta.
    t_word w_sdf_r, w_eq_r, w_m1, w_m2;
    t_word w_sdf_m, w_eq_m, w_r_m, w_xq_m;

    tpf_dly #(.P_WIDTH(64), .P_DEPTH(T_R - T_SDF)) u_sdf_dly (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_d(w_sdf), .o_d(w_sdf_r)
    );
    tpf_dly #(.P_WIDTH(64), .P_DEPTH(T_R - T_CONV)) u_eq_dly (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_d(r_eq), .o_d(w_eq_r)
    );

    tpf_qmul u_m1 (.i_clk(i_clk), .i_en(w_en), .i_a(w_eq_r), .i_b(w_r), .o_p(w_m1));
    tpf_qmul u_m2 (.i_clk(i_clk), .i_en(w_en), .i_a(w_sdf_r), .i_b(w_eq_r), .o_p(w_m2));

    tpf_dly #(.P_WIDTH(64), .P_DEPTH(QL)) u_sdf_m_dly (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_d(w_sdf_r), .o_d(w_sdf_m)
    );
    tpf_dly #(.P_WIDTH(64), .P_DEPTH(QL)) u_eq_m_dly (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_d(w_eq_r), .o_d(w_eq_m)
    );
    tpf_dly #(.P_WIDTH(64), .P_DEPTH(QL)) u_r_m_dly (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_d(w_r), .o_d(w_r_m)
    );
    tpf_dly #(.P_WIDTH(64), .P_DEPTH(T_M - T_CONV)) u_xq_dly (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_d(r_xq), .o_d(w_xq_m)
    );

    // Operands of the four arctangents. When xi and r are both zero, r is
    // taken as one once the first solution's numerator and denominator are
    // formed; eta*r for the second solution is then eta itself. The second
    // solution uses -r, so eta*(-r) is just the negated first product.
    t_word r_s1, r_c1, r_s2, r_c2, r_rr, r_xq2;
    logic  r_two;
    logic  n_deg;
    t_word n_rr, n_m1p, n_mag;

    always_comb begin
        n_deg = (w_xq_m == '0) && (w_r_m == '0);
        n_rr  = n_deg ? Q_ONE : w_r_m;
        n_m1p = n_deg ? w_eq_m : w_m1;
        n_mag = w_sdf_m[63] ? -w_sdf_m : w_sdf_m;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1  <= sat_add(w_sdf_m, -w_m1);
            r_c1  <= sat_add(w_m2, w_r_m);
            r_s2  <= sat_add(w_sdf_m, n_m1p);
            r_c2  <= sat_add(w_m2, -n_rr);
            r_rr  <= n_rr;
            r_xq2 <= w_xq_m;
            r_two <= (n_mag >= Q_ONE);
        end
    end

    t_word w_a1, w_a2, w_d1, w_d2;

    tpf_atan2 #(.P_STEPS(P_CORDIC_STEPS)) u_at_ra1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_y(r_xq2), .i_x(r_rr), .o_z(w_a1)
    );
    tpf_atan2 #(.P_STEPS(P_CORDIC_STEPS)) u_at_ra2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_y(r_xq2), .i_x(-r_rr), .o_z(w_a2)
    );
    tpf_atan2 #(.P_STEPS(P_CORDIC_STEPS)) u_at_dec1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_y(r_s1), .i_x(r_c1), .o_z(w_d1)
    );
    tpf_atan2 #(.P_STEPS(P_CORDIC_STEPS)) u_at_dec2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_y(r_s2), .i_x(r_c2), .o_z(w_d2)
    );

    // Side values carried to the output stage.
    logic [31:0] w_ra_d;
    logic        w_two_d;
    logic        w_vld_d;

    tpf_dly #(.P_WIDTH(32), .P_DEPTH(T_AT - T_CONV)) u_ra_dly (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_d(r_ra), .o_d(w_ra_d)
    );
    tpf_dly #(.P_WIDTH(1), .P_DEPTH(L_AT)) u_two_dly (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_d(r_two), .o_d(w_two_d)
    );
    tpf_dly #(.P_WIDTH(1), .P_DEPTH(T_AT), .P_CLEAR(1'b1)) u_vld_dly (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_d(i_req.valid), .o_d(w_vld_d)
    );

    // Output register: RA wraps modulo a full turn; no solution gives zeros.
    t_out_req n_out;

    always_comb begin
        n_out.solution_count = w_two_d ? CNT_TWO : CNT_ONE;
        n_out.first_ra       = w_ra_d - w_a1[31:0];
        n_out.first_dec      = w_d1[31:0];
        n_out.second_ra      = w_ra_d - w_a2[31:0];
        n_out.second_dec     = w_d2[31:0];
        if (w_none_d) begin
            n_out                = '0;
            n_out.solution_count = CNT_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_vld_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) r_out <= n_out;
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    // A result without solutions carries all angles as zero.
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.data.solution_count == CNT_NONE |->
            o_rsp.data.first_ra == '0 && o_rsp.data.first_dec == '0 &&
            o_rsp.data.second_ra == '0 && o_rsp.data.second_dec == '0)
        else $error("no-solution result with nonzero angle");

    a_count_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> o_rsp.data.solution_count != 2'd3)
        else $error("invalid solution count");

    // A stalled result must freeze the whole pipeline, intake included.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.ready |-> !i_req.ready)
        else $error("request taken while output stalled");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.ready |=> o_rsp.valid && $stable(o_rsp.data))
        else $error("stalled result changed");

endmodule

@@ src/tpf_dly.sv @@
// Delay line of registers that shifts whenever the pipeline advances.
// Depends on nothing.
module tpf_dly #(
    parameter int P_WIDTH = 64,
    parameter int P_DEPTH = 1,
    parameter bit P_CLEAR = 1'b0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic [P_WIDTH-1:0] i_d,
    output logic [P_WIDTH-1:0] o_d
);
    logic [P_WIDTH-1:0] r_tap [P_DEPTH];

    always_ff @(posedge i_clk) begin
        if (P_CLEAR && !i_rst_n) begin
            for (int k = 0; k < P_DEPTH; k++) r_tap[k] <= '0;
        end else if (i_en) begin
            r_tap[0] <= i_d;
            for (int k = 1; k < P_DEPTH; k++) r_tap[k] <= r_tap[k-1];
        end
    end

    assign o_d = r_tap[P_DEPTH-1];
endmodule

@@ src/tpf_qmul.sv @@
// Pipelined Q32 multiply: four 32x32 partial products, round to nearest
// (ties away from zero), saturate. Depends on tpf_pkg.
module tpf_qmul (
    input  logic          i_clk,
    input  logic          i_en,
    input  tpf_pkg::t_word i_a,
    input  tpf_pkg::t_word i_b,
    output tpf_pkg::t_word o_p
);
    import tpf_pkg::*;

    logic        r_neg1, r_neg2, r_neg3;
    logic [63:0] r_ua, r_ub;
    logic [63:0] r_p00, r_p01, r_p10, r_p11;
    logic [63:0] r_lo, r_hi;
    t_word       r_p;

    logic [63:0] n_ua, n_ub;
    logic [33:0] n_mid;
    logic [63:0] n_lo, n_hi;
    logic [63:0] n_res;
    t_word       n_p;

    always_comb begin
        n_ua  = i_a[63] ? 64'd0 - i_a : i_a;
        n_ub  = i_b[63] ? 64'd0 - i_b : i_b;
        n_mid = 34'(r_p00[63:32]) + 34'(r_p01[31:0]) + 34'(r_p10[31:0]);
        n_lo  = {n_mid[31:0], r_p00[31:0]};
        n_hi  = r_p11 + 64'(r_p01[63:32]) + 64'(r_p10[63:32]) + 64'(n_mid[33:32]);
        n_res = {r_hi[31:0], r_lo[63:32]} + 64'(r_lo[31]);
        if (r_hi[63:31] != '0 || n_res[63]) n_res = Q_MAX;
        n_p = r_neg3 ? -t_word'(n_res) : t_word'(n_res);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg1 <= i_a[63] ^ i_b[63];
            r_ua   <= n_ua;
            r_ub   <= n_ub;
            r_neg2 <= r_neg1;
            r_p00  <= r_ua[31:0]  * r_ub[31:0];
            r_p01  <= r_ua[31:0]  * r_ub[63:32];
            r_p10  <= r_ua[63:32] * r_ub[31:0];
            r_p11  <= r_ua[63:32] * r_ub[63:32];
            r_neg3 <= r_neg2;
            r_lo   <= n_lo;
            r_hi   <= n_hi;
            r_p    <= n_p;
        end
    end

    assign o_p = r_p;
endmodule

@@ src/tpf_sqrt_cell.sv @@
// One digit of the restoring integer square root (floor, Q32 result).
// Depends on tpf_pkg.
module tpf_sqrt_cell #(
    parameter int P_K = 0
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  tpf_pkg::t_sqrt i_d,
    output tpf_pkg::t_sqrt o_d
);
    import tpf_pkg::*;

    localparam bit HAS_PAIR = (2 * P_K >= 32);
    localparam int SH       = HAS_PAIR ? 2 * P_K - 32 : 0;

    t_sqrt       r_d;
    t_sqrt       n_d;
    logic [63:0] pair;
    logic [63:0] trial;

    always_comb begin
        pair     = HAS_PAIR ? ((i_d.v >> SH) & 64'd3) : 64'd0;
        n_d      = i_d;
        n_d.rem  = (i_d.rem << 2) | pair;
        trial    = (i_d.root << 2) | 64'd1;
        n_d.root = i_d.root << 1;
        if (n_d.rem >= trial) begin
            n_d.rem     = n_d.rem - trial;
            n_d.root[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_d <= n_d;
    end

    assign o_d = r_d;
endmodule

@@ src/tpf_cordic_cell.sv @@
// One CORDIC micro-rotation, rotation or vectoring mode, with its own
// arctangent constant. Depends on tpf_pkg.
module tpf_cordic_cell #(
    parameter int P_STEP = 0,
    parameter bit P_VEC  = 1'b0
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  tpf_pkg::t_cordic i_d,
    output tpf_pkg::t_cordic o_d
);
    import tpf_pkg::*;

    localparam t_word ATAB = atan_entry(P_STEP);

    t_cordic r_d;
    t_cordic n_d;
    t_word   dx, dy;
    logic    up;

    always_comb begin
        dx = $signed(i_d.y) >>> P_STEP;
        dy = $signed(i_d.x) >>> P_STEP;
        // Vectoring drives y to zero; rotation drives z to zero.
        up = P_VEC ? i_d.y[63] : !i_d.z[63];
        if (P_VEC ? !up : up) begin
            n_d.x = P_VEC ? i_d.x + dx : i_d.x - dx;
            n_d.y = P_VEC ? i_d.y - dy : i_d.y + dy;
            n_d.z = P_VEC ? i_d.z + ATAB : i_d.z - ATAB;
        end else begin
            n_d.x = P_VEC ? i_d.x - dx : i_d.x + dx;
            n_d.y = P_VEC ? i_d.y + dy : i_d.y - dy;
            n_d.z = P_VEC ? i_d.z - ATAB : i_d.z + ATAB;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_d <= n_d;
    end

    assign o_d = r_d;
endmodule

@@ src/tpf_atan2.sv @@
// Pipelined atan2: operand prescale, half-turn fold, a chain of vectoring
// cells and a zero-vector override. Depends on tpf_pkg, tpf_dly, tpf_cordic_cell.
module tpf_atan2 #(
    parameter int P_STEPS = tpf_pkg::CORDIC_STEPS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  tpf_pkg::t_word i_y,
    input  tpf_pkg::t_word i_x,
    output tpf_pkg::t_word o_z
);
    import tpf_pkg::*;

    t_word   r_x, r_y;
    logic    r_zero;
    t_cordic r_fold;
    t_word   r_z;
    t_word   n_x, n_y, xs, ys;
    t_cordic n_fold;
    t_cordic w_chain [P_STEPS+1];
    logic    w_zero_d;

    // Smallest common right shift that brings both magnitudes below 2^60.
    always_comb begin
        n_x = $signed(i_x) >>> 4;
        n_y = $signed(i_y) >>> 4;
        for (int k = 4; k >= 0; k--) begin
            xs = $signed(i_x) >>> k;
            ys = $signed(i_y) >>> k;
            if (xs < BIG_LIM && xs > -BIG_LIM && ys < BIG_LIM && ys > -BIG_LIM) begin
                n_x = xs;
                n_y = ys;
            end
        end
    end

    always_comb begin
        n_fold.x = r_x;
        n_fold.y = r_y;
        n_fold.z = '0;
        if (r_x[63]) begin
            n_fold.z = r_y[63] ? -HALF_T : HALF_T;
            n_fold.x = -r_x;
            n_fold.y = -r_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_zero <= (i_x == '0) && (i_y == '0);
            r_fold <= n_fold;
            r_z    <= w_zero_d ? t_word'(0) : w_chain[P_STEPS].z;
        end
    end

    assign w_chain[0] = r_fold;

    for (genvar g = 0; g < P_STEPS; g++) begin : g_cell
        tpf_cordic_cell #(.P_STEP(g), .P_VEC(1'b1)) u_cell (
            .i_clk(i_clk), .i_en(i_en), .i_d(w_chain[g]), .o_d(w_chain[g+1])
        );
    end

    tpf_dly #(.P_WIDTH(1), .P_DEPTH(P_STEPS + 1)) u_zero_dly (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(i_en), .i_d(r_zero), .o_d(w_zero_d)
    );

    assign o_z = r_z;
endmodule
